### sv/tmb_pkg.sv
// shared constants, codes and types of the timer bank
package tmb_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int SLOT_CAP    = 16;
  localparam int SLOT_COUNT  = (NUM_TIMERS < SLOT_CAP) ? NUM_TIMERS : SLOT_CAP;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input action codes
  localparam logic [2:0] ACT_INIT    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_STOP    = 3'd2;
  localparam logic [2:0] ACT_DESTROY = 3'd3;
  localparam logic [2:0] ACT_TICK    = 3'd4;
  localparam logic [2:0] ACT_INFO    = 3'd5;

  // classified operations handed to the back end
  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_STOP    = 3'd2;
  localparam logic [2:0] OP_DESTROY = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;
  localparam logic [2:0] OP_INFO    = 3'd5;
  localparam logic [2:0] OP_NOP     = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_INFO  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // slot state codes
  localparam logic [2:0] SS_CREATED   = 3'd0;
  localparam logic [2:0] SS_STARTED   = 3'd1;
  localparam logic [2:0] SS_RUNNING   = 3'd2;
  localparam logic [2:0] SS_STOPPED   = 3'd3;
  localparam logic [2:0] SS_DESTROYED = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       delay;
    logic [31:0]       period;
    logic              hard;
    logic [31:0]       tag;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic [31:0] delay;
    logic [31:0] period;
    logic        hard;
    logic [2:0]  st;
    logic        last;
  } res_t;

endpackage

### sv/tmb_if.sv
// valid/ready channel interfaces for requests and results
interface tmb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [3:0]  timer_index;
  logic [31:0] start_delay;
  logic [31:0] period;
  logic        hard_kind;
  logic [31:0] user_tag;

  modport source (output valid, action, timer_index, start_delay, period, hard_kind,
                  user_tag, input ready);
  modport sink (input valid, action, timer_index, start_delay, period, hard_kind,
                user_tag, output ready);
endinterface

interface tmb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  slot_out;
  logic [31:0] tag_out;
  logic [31:0] info_start_delay;
  logic [31:0] info_period;
  logic        info_hard;
  logic [2:0]  slot_state;
  logic        last;

  modport source (output valid, result_kind, slot_out, tag_out, info_start_delay,
                  info_period, info_hard, slot_state, last, input ready);
  modport sink (input valid, result_kind, slot_out, tag_out, info_start_delay,
                info_period, info_hard, slot_state, last, output ready);
endinterface

### sv/tmb_front.sv
// request front end: accepts beats and classifies them into operations
module tmb_front (
  tmb_in_if.sink          cmd,
  input  logic            q_full,
  output logic            push,
  output tmb_pkg::cmd_t   push_cmd
);

  logic ok;

  always_comb begin
    ok = {1'b0, cmd.timer_index} < 5'(tmb_pkg::SLOT_COUNT);
    cmd.ready = !q_full;
    push = cmd.valid && !q_full;
    push_cmd.slot   = cmd.timer_index[tmb_pkg::SLOT_W-1:0];
    push_cmd.delay  = cmd.start_delay;
    push_cmd.period = cmd.period;
    push_cmd.hard   = cmd.hard_kind;
    push_cmd.tag    = cmd.user_tag;
    unique case (cmd.action)
      tmb_pkg::ACT_INIT:    push_cmd.op = ok ? tmb_pkg::OP_INIT : tmb_pkg::OP_NOP;
      tmb_pkg::ACT_START:   push_cmd.op = ok ? tmb_pkg::OP_START : tmb_pkg::OP_NOP;
      tmb_pkg::ACT_STOP:    push_cmd.op = ok ? tmb_pkg::OP_STOP : tmb_pkg::OP_NOP;
      tmb_pkg::ACT_DESTROY: push_cmd.op = ok ? tmb_pkg::OP_DESTROY : tmb_pkg::OP_NOP;
      tmb_pkg::ACT_TICK:    push_cmd.op = tmb_pkg::OP_TICK;
      tmb_pkg::ACT_INFO:    push_cmd.op = ok ? tmb_pkg::OP_INFO : tmb_pkg::OP_NOP;
      default:              push_cmd.op = tmb_pkg::OP_NOP;
    endcase
  end

endmodule

### sv/tmb_queue.sv
// short operation queue between front and back end
module tmb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tmb_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output tmb_pkg::cmd_t head_cmd,
  input  logic          pop
);

  tmb_pkg::cmd_t                 slots [tmb_pkg::QUEUE_DEPTH];
  logic [tmb_pkg::QPTR_W-1:0]    wp;
  logic [tmb_pkg::QPTR_W-1:0]    rp;
  logic [tmb_pkg::QCNT_W-1:0]    count;

  always_comb begin
    full       = count == tmb_pkg::QCNT_W'(tmb_pkg::QUEUE_DEPTH);
    head_valid = count != '0;
    head_cmd   = slots[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wp] <= push_cmd;
        wp        <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= tmb_pkg::QCNT_W'(tmb_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

### sv/tmb_back.sv
// back end: slot storage, command execution, tick scan and result register
module tmb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tmb_pkg::cmd_t q_cmd,
  output logic          q_pop,
  tmb_out_if.source     res
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SCAN = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  logic [31:0] dly [tmb_pkg::SLOT_COUNT];
  logic [31:0] per [tmb_pkg::SLOT_COUNT];
  logic [31:0] rem [tmb_pkg::SLOT_COUNT];
  logic        hrd [tmb_pkg::SLOT_COUNT];
  logic [31:0] tag [tmb_pkg::SLOT_COUNT];
  logic [2:0]  sst [tmb_pkg::SLOT_COUNT];
  logic        act [tmb_pkg::SLOT_COUNT];

  logic [1:0]                 state;
  logic                       grp;
  logic [tmb_pkg::SLOT_W-1:0] scan_idx;
  tmb_pkg::res_t              ores;
  logic                       ores_valid;

  logic                       go;
  logic                       ld;
  tmb_pkg::res_t              ld_res;
  logic [tmb_pkg::SLOT_W-1:0] addr;
  logic [31:0]                r_dly;
  logic [31:0]                r_per;
  logic [31:0]                r_rem;
  logic                       r_hrd;
  logic [31:0]                r_tag;
  logic [2:0]                 r_st;
  logic                       r_act;
  logic [31:0]                first_cnt;
  logic                       sel;
  logic                       fires;
  logic                       scan_last;
  tmb_pkg::res_t              done_res;

  always_comb begin
    go        = !ores_valid || res.ready;
    addr      = (state == B_SCAN) ? scan_idx : q_cmd.slot;
    r_dly     = dly[addr];
    r_per     = per[addr];
    r_rem     = rem[addr];
    r_hrd     = hrd[addr];
    r_tag     = tag[addr];
    r_st      = sst[addr];
    r_act     = act[addr];
    first_cnt = (r_dly != '0) ? r_dly : r_per;
    sel       = r_act && (r_hrd == grp);
    fires     = (r_rem == 32'd0) || (r_rem == 32'd1);
    scan_last = scan_idx == tmb_pkg::SLOT_W'(tmb_pkg::SLOT_COUNT - 1);
    q_pop     = (state == B_IDLE) && q_valid && go;

    done_res      = '0;
    done_res.kind = tmb_pkg::KIND_DONE;
    done_res.last = 1'b1;

    ld     = 1'b0;
    ld_res = done_res;
    unique case (state)
      B_IDLE: begin
        if (q_pop && q_cmd.op != tmb_pkg::OP_TICK) begin
          ld = 1'b1;
          if (q_cmd.op == tmb_pkg::OP_INFO) begin
            ld_res        = '0;
            ld_res.kind   = tmb_pkg::KIND_INFO;
            ld_res.slot   = 4'(addr);
            ld_res.tag    = r_tag;
            ld_res.delay  = r_dly;
            ld_res.period = r_per;
            ld_res.hard   = r_hrd;
            ld_res.st     = r_st;
          end
        end
      end
      B_SCAN: begin
        if (go && sel && fires) begin
          ld          = 1'b1;
          ld_res      = '0;
          ld_res.kind = tmb_pkg::KIND_FIRED;
          ld_res.slot = 4'(addr);
          ld_res.tag  = r_tag;
          ld_res.st   = (r_per != '0) ? tmb_pkg::SS_STARTED : tmb_pkg::SS_STOPPED;
        end
      end
      B_DONE: begin
        ld = go;
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      grp        <= 1'b0;
      scan_idx   <= '0;
      ores_valid <= 1'b0;
      for (int i = 0; i < tmb_pkg::SLOT_COUNT; i++) begin
        dly[i] <= '0;
        per[i] <= '0;
        rem[i] <= '0;
        hrd[i] <= 1'b0;
        tag[i] <= '0;
        sst[i] <= tmb_pkg::SS_DESTROYED;
        act[i] <= 1'b0;
      end
    end else begin
      if (ld) begin
        ores       <= ld_res;
        ores_valid <= 1'b1;
      end else if (res.ready) begin
        ores_valid <= 1'b0;
      end

      unique case (state)
        B_IDLE: begin
          if (q_pop) begin
            unique case (q_cmd.op)
              tmb_pkg::OP_INIT: begin
                dly[addr] <= q_cmd.delay;
                per[addr] <= q_cmd.period;
                hrd[addr] <= q_cmd.hard;
                tag[addr] <= q_cmd.tag;
                rem[addr] <= (q_cmd.delay != '0) ? q_cmd.delay : q_cmd.period;
                act[addr] <= 1'b0;
                sst[addr] <= tmb_pkg::SS_CREATED;
              end
              tmb_pkg::OP_START: begin
                if (r_st == tmb_pkg::SS_CREATED || r_st == tmb_pkg::SS_STOPPED) begin
                  rem[addr] <= first_cnt;
                  sst[addr] <= tmb_pkg::SS_STARTED;
                  act[addr] <= 1'b1;
                end
              end
              tmb_pkg::OP_STOP: begin
                if (r_st == tmb_pkg::SS_STARTED || r_st == tmb_pkg::SS_RUNNING) begin
                  act[addr] <= 1'b0;
                  sst[addr] <= tmb_pkg::SS_STOPPED;
                end
              end
              tmb_pkg::OP_DESTROY: begin
                act[addr] <= 1'b0;
                sst[addr] <= tmb_pkg::SS_DESTROYED;
              end
              tmb_pkg::OP_TICK: begin
                state    <= B_SCAN;
                grp      <= 1'b1;
                scan_idx <= '0;
              end
              tmb_pkg::OP_INFO: begin
                state <= B_DONE;
              end
              default: begin
                state <= B_IDLE;
              end
            endcase
          end
        end
        B_SCAN: begin
          if (go) begin
            if (sel) begin
              if (fires) begin
                if (r_per != '0) begin
                  rem[addr] <= r_per;
                  sst[addr] <= tmb_pkg::SS_STARTED;
                end else begin
                  act[addr] <= 1'b0;
                  sst[addr] <= tmb_pkg::SS_STOPPED;
                end
              end else begin
                rem[addr] <= r_rem - 32'd1;
              end
            end
            if (scan_last) begin
              scan_idx <= '0;
              if (grp) begin
                grp <= 1'b0;
              end else begin
                state <= B_DONE;
              end
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
        end
        B_DONE: begin
          if (go) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.valid            = ores_valid;
    res.result_kind      = ores.kind;
    res.slot_out         = ores.slot;
    res.tag_out          = ores.tag;
    res.info_start_delay = ores.delay;
    res.info_period      = ores.period;
    res.info_hard        = ores.hard;
    res.slot_state       = ores.st;
    res.last             = ores.last;
  end

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    state == B_SCAN |=> state == B_SCAN || state == B_DONE)
    else $error("scan left without done marker");

  a_active_started: assert property (@(posedge clk) disable iff (rst)
    r_act |-> (r_st == tmb_pkg::SS_STARTED || r_st == tmb_pkg::SS_RUNNING))
    else $error("listed slot not in a started state");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (ores_valid && ores.last) |->
      (ores.kind == tmb_pkg::KIND_DONE && ores.tag == '0 && ores.slot == '0))
    else $error("done marker carries payload");

endmodule

### sv/oneshot_periodic_timer_bank.sv
// top level of the one-shot/periodic countdown timer bank
//
//   channel  dir  beat contents
//   -------  ---  -------------------------------------------------------------
//   cmd      in   action, timer_index, start_delay, period, hard_kind, user_tag
//   res      out  result_kind, slot_out, tag_out, info_*, slot_state, last
//
// init/start/stop/destroy give only a done beat;
// info gives a report beat, then a done beat
// tick: after the pop, the back end walks every slot once for the hard group and
// once for the soft group, one slot a cycle while res does not stall, then gives
// the done beat
// reset clears all slot stores at once (states to destroyed); no clearing pass
// a stall on res holds the back end; the two-entry queue keeps cmd taking beats until full
module oneshot_periodic_timer_bank (
  input logic       clk,
  input logic       rst,
  tmb_in_if.sink    cmd,
  tmb_out_if.source res
);

  // classified operation from the front end
  logic          push;
  tmb_pkg::cmd_t push_cmd;
  logic          q_full;

  // head of the queue as seen by the back end
  logic          head_valid;
  tmb_pkg::cmd_t head_cmd;
  logic          pop;

  // decode action and range-check the slot index; out-of-range slots become no-ops
  tmb_front u_front (
    .cmd      (cmd),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples the request side from the slower back end
  tmb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // slot storage, tick scan and registered result beat
  tmb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (head_valid),
    .q_cmd   (head_cmd),
    .q_pop   (pop),
    .res     (res)
  );

endmodule

### test/tb_top.sv
// self-checking testbench of the one-shot/periodic timer bank
`timescale 1ns / 1ps

module tb_top;

  // one command beat as the driver sees it
  typedef struct {
    logic [2:0]  action;
    logic [3:0]  idx;
    logic [31:0] delay;
    logic [31:0] period;
    logic        hard;
    logic [31:0] tag;
  } cmd_beat_t;

  localparam int RANDOM_CMDS  = 184;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 22;
  localparam int HOLD_CYCLES  = 250;
  localparam int HOLD_AT_BEAT = 150;
  // windows with no idling at all
  localparam int CMD_QUIET_LO = 120;
  localparam int CMD_QUIET_HI = 165;
  localparam int RES_QUIET_LO = 180;
  localparam int RES_QUIET_HI = 300;
  localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

  logic clk;
  logic rst;

  tmb_in_if  cmd_if ();
  tmb_out_if res_if ();

  oneshot_periodic_timer_bank i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  // commands waiting to be driven, and result beats the bank must still produce
  cmd_beat_t     cmd_queue[$];
  tmb_pkg::res_t expected_results[$];

  // shadow copy of the slot stores
  logic [31:0] dly_mem [tmb_pkg::SLOT_CAP];
  logic [31:0] per_mem [tmb_pkg::SLOT_CAP];
  logic [31:0] cnt_mem [tmb_pkg::SLOT_CAP];
  logic        hard_mem[tmb_pkg::SLOT_CAP];
  logic [31:0] tag_mem [tmb_pkg::SLOT_CAP];
  logic [2:0]  st_mem  [tmb_pkg::SLOT_CAP];
  logic        act_mem [tmb_pkg::SLOT_CAP];

  int cycle_count = 0;
  int cmds_issued = 0;
  int ticks_issued = 0;
  int beats_seen = 0;
  int expiries = 0;
  int err_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // clock and the single reset pulse
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // known levels on every bank input before the first edge
  initial begin
    cmd_if.valid       = 1'b0;
    cmd_if.action      = tmb_pkg::ACT_INIT;
    cmd_if.timer_index = '0;
    cmd_if.start_delay = '0;
    cmd_if.period      = '0;
    cmd_if.hard_kind   = 1'b0;
    cmd_if.user_tag    = '0;
    res_if.ready       = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("watchdog expired after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  initial begin
    for (int s = 0; s < tmb_pkg::SLOT_CAP; s++) begin
      dly_mem[s]  = '0;
      per_mem[s]  = '0;
      cnt_mem[s]  = '0;
      hard_mem[s] = 1'b0;
      tag_mem[s]  = '0;
      st_mem[s]   = tmb_pkg::SS_DESTROYED;
      act_mem[s]  = 1'b0;
    end
  end

  function automatic void push_result(logic [1:0] kind, logic [3:0] slot, logic [31:0] tag,
                                      logic [31:0] dly, logic [31:0] per, logic hard,
                                      logic [2:0] st, logic last);
    tmb_pkg::res_t r;
    r.kind   = kind;
    r.slot   = slot;
    r.tag    = tag;
    r.delay  = dly;
    r.period = per;
    r.hard   = hard;
    r.st     = st;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  // count loaded by init and start: the start delay, or the period when that is zero
  function automatic logic [31:0] reload_value(int s);
    return (dly_mem[s] != 0) ? dly_mem[s] : per_mem[s];
  endfunction

  // apply one accepted command to the shadow bank and queue what it must produce
  function automatic void advance_bank(cmd_beat_t b);
    int  s;
    bit  ok;
    logic want_hard;
    s  = int'(b.idx);
    ok = s < tmb_pkg::SLOT_COUNT;
    case (b.action)
      tmb_pkg::ACT_INIT: if (ok) begin
        dly_mem[s]  = b.delay;
        per_mem[s]  = b.period;
        hard_mem[s] = b.hard;
        tag_mem[s]  = b.tag;
        cnt_mem[s]  = reload_value(s);
        act_mem[s]  = 1'b0;
        st_mem[s]   = tmb_pkg::SS_CREATED;
      end
      tmb_pkg::ACT_START: if (ok && (st_mem[s] == tmb_pkg::SS_CREATED ||
                                     st_mem[s] == tmb_pkg::SS_STOPPED)) begin
        cnt_mem[s] = reload_value(s);
        st_mem[s]  = tmb_pkg::SS_STARTED;
        act_mem[s] = 1'b1;
      end
      tmb_pkg::ACT_STOP: if (ok && (st_mem[s] == tmb_pkg::SS_STARTED ||
                                    st_mem[s] == tmb_pkg::SS_RUNNING)) begin
        act_mem[s] = 1'b0;
        st_mem[s]  = tmb_pkg::SS_STOPPED;
      end
      tmb_pkg::ACT_DESTROY: if (ok) begin
        act_mem[s] = 1'b0;
        st_mem[s]  = tmb_pkg::SS_DESTROYED;
      end
      tmb_pkg::ACT_TICK: begin
        // hard group first, then soft, each in ascending slot order
        for (int g = 0; g < 2; g++) begin
          want_hard = (g == 0);
          for (int t = 0; t < tmb_pkg::SLOT_COUNT; t++) begin
            if (act_mem[t] && hard_mem[t] == want_hard) begin
              // a count already at zero fires without a decrement
              if (cnt_mem[t] != 0) cnt_mem[t] = cnt_mem[t] - 1;
              if (cnt_mem[t] == 0) begin
                if (per_mem[t] != 0) begin
                  cnt_mem[t] = per_mem[t];
                  st_mem[t]  = tmb_pkg::SS_STARTED;
                end else begin
                  // one-shot leaves the active set
                  act_mem[t] = 1'b0;
                  st_mem[t]  = tmb_pkg::SS_STOPPED;
                end
                push_result(tmb_pkg::KIND_FIRED, 4'(t), tag_mem[t], '0, '0, 1'b0,
                            st_mem[t], 1'b0);
                expiries++;
              end
            end
          end
        end
      end
      tmb_pkg::ACT_INFO: if (ok) begin
        push_result(tmb_pkg::KIND_INFO, 4'(s), tag_mem[s], dly_mem[s], per_mem[s],
                    hard_mem[s], st_mem[s], 1'b0);
      end
      default: ;  // undefined actions only close with the done beat
    endcase
    push_result(tmb_pkg::KIND_DONE, '0, '0, '0, '0, 1'b0, '0, 1'b1);
  endfunction

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------

  function automatic void push_cmd(logic [2:0] action, logic [3:0] idx, logic [31:0] dly,
                                   logic [31:0] per, logic hard, logic [31:0] tag);
    cmd_beat_t b;
    b.action = action;
    b.idx    = idx;
    b.delay  = dly;
    b.period = per;
    b.hard   = hard;
    b.tag    = tag;
    cmd_queue.push_back(b);
  endfunction

  // mostly short counts so slots expire often, now and then the full range
  function automatic logic [31:0] rand_count();
    return ($urandom_range(99) < 10) ? $urandom : 32'($urandom_range(4));
  endfunction

  function automatic void fill_directed();
    // slot never initialized: destroyed, stores zero; start and stop ignored
    push_cmd(tmb_pkg::ACT_INFO,  4'd0, $urandom, $urandom, 1'b1, $urandom);
    push_cmd(tmb_pkg::ACT_START, 4'd0, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_STOP,  4'd0, '0, '0, 1'b0, '0);
    // zero delay and zero period: count zero, one-shot
    push_cmd(tmb_pkg::ACT_INIT,  4'd0, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
    // hard periodic, soft slot whose start delay falls back to the period
    push_cmd(tmb_pkg::ACT_INIT,  4'd15, 32'd2, 32'd3, 1'b1, 32'hA5A5_5A5A);
    push_cmd(tmb_pkg::ACT_INIT,  4'd7, 32'd0, 32'd2, 1'b0, 32'd0);
    // largest counts
    push_cmd(tmb_pkg::ACT_INIT,  4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678);
    push_cmd(tmb_pkg::ACT_START, 4'd0, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_START, 4'd15, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_START, 4'd7, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_START, 4'd3, '0, '0, 1'b0, '0);
    // start of a slot already started is ignored
    push_cmd(tmb_pkg::ACT_START, 4'd15, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_TICK,  4'd9, $urandom, $urandom, 1'b1, $urandom);
    // hard slot 15 must come out before soft slot 7
    push_cmd(tmb_pkg::ACT_TICK,  4'd0, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_INFO,  4'd15, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_STOP,  4'd3, '0, '0, 1'b0, '0);
    // stop of a stopped slot is ignored
    push_cmd(tmb_pkg::ACT_STOP,  4'd3, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_INFO,  4'd3, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_TICK,  4'd0, '0, '0, 1'b0, '0);
    push_cmd(ACT_UNDEF_LO, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_cmd(ACT_UNDEF_HI, 4'd0, $urandom, $urandom, 1'b0, $urandom);
    push_cmd(tmb_pkg::ACT_DESTROY, 4'd15, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_INFO,  4'd15, '0, '0, 1'b0, '0);
    // destroyed slot cannot be started; a stopped one with count zero restarts
    push_cmd(tmb_pkg::ACT_START, 4'd15, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_START, 4'd0, '0, '0, 1'b0, '0);
    push_cmd(tmb_pkg::ACT_TICK,  4'd0, '0, '0, 1'b0, '0);
  endfunction

  function automatic void fill_random();
    int n;
    int r;
    logic [3:0] idx;
    n = 0;
    while (n < RANDOM_CMDS) begin
      r   = $urandom_range(99);
      idx = 4'($urandom_range(15));
      if (r < 18) begin
        push_cmd(tmb_pkg::ACT_INIT, idx, rand_count(), rand_count(), 1'($urandom),
                 $urandom);
        n++;
        // usually armed right away
        if ($urandom_range(99) < 60) begin
          push_cmd(tmb_pkg::ACT_START, idx, $urandom, $urandom, 1'($urandom), $urandom);
          n++;
        end
      end else begin
        if (r < 34)
          push_cmd(tmb_pkg::ACT_START, idx, $urandom, $urandom, 1'($urandom), $urandom);
        else if (r < 42)
          push_cmd(tmb_pkg::ACT_STOP, idx, $urandom, $urandom, 1'($urandom), $urandom);
        else if (r < 46)
          push_cmd(tmb_pkg::ACT_DESTROY, idx, $urandom, $urandom, 1'($urandom), $urandom);
        else if (r < 82)
          push_cmd(tmb_pkg::ACT_TICK, idx, $urandom, $urandom, 1'($urandom), $urandom);
        else if (r < 94)
          push_cmd(tmb_pkg::ACT_INFO, idx, $urandom, $urandom, 1'($urandom), $urandom);
        else push_cmd(($urandom_range(1) != 0) ? ACT_UNDEF_HI : ACT_UNDEF_LO, idx,
                      $urandom, $urandom, 1'($urandom), $urandom);
        n++;
      end
    end
  endfunction

  // ------------------------------------------------------------------------
  // driver: offers queued commands, predicts each one at acceptance
  // ------------------------------------------------------------------------

  always @(posedge clk) begin : cmd_driver
    cmd_beat_t nxt;
    cmd_beat_t taken;
    bit        quiet;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        taken.action = cmd_if.action;
        taken.idx    = cmd_if.timer_index;
        taken.delay  = cmd_if.start_delay;
        taken.period = cmd_if.period;
        taken.hard   = cmd_if.hard_kind;
        taken.tag    = cmd_if.user_tag;
        advance_bank(taken);
        cmds_issued++;
        if (taken.action == tmb_pkg::ACT_TICK) ticks_issued++;
      end
      // a held beat stays put; otherwise pick the next one or idle
      if (!cmd_if.valid || cmd_if.ready) begin
        quiet = cmds_issued >= CMD_QUIET_LO && cmds_issued < CMD_QUIET_HI;
        if (cmd_queue.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = cmd_queue.pop_front();
          cmd_if.valid       <= 1'b1;
          cmd_if.action      <= nxt.action;
          cmd_if.timer_index <= nxt.idx;
          cmd_if.start_delay <= nxt.delay;
          cmd_if.period      <= nxt.period;
          cmd_if.hard_kind   <= nxt.hard;
          cmd_if.user_tag    <= nxt.tag;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // long hold-off of the result side, once, so the bank backs up into cmd
  // ------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ------------------------------------------------------------------------
  // monitor: compares every result beat with the oldest expectation
  // ------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h (result beat %0d)", name, want, got, beats_seen);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : res_monitor
    tmb_pkg::res_t want;
    bit            quiet;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        beats_seen <= beats_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: kind %0d slot %0d",
                 res_if.result_kind, res_if.slot_out);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind",      32'(want.kind),   32'(res_if.result_kind));
          check_field("slot_out",         32'(want.slot),   32'(res_if.slot_out));
          check_field("tag_out",          want.tag,         res_if.tag_out);
          check_field("info_start_delay", want.delay,       res_if.info_start_delay);
          check_field("info_period",      want.period,      res_if.info_period);
          check_field("info_hard",        32'(want.hard),   32'(res_if.info_hard));
          check_field("slot_state",       32'(want.st),     32'(res_if.slot_state));
          check_field("last",             32'(want.last),   32'(res_if.last));
        end
      end
      quiet = beats_seen >= RES_QUIET_LO && beats_seen < RES_QUIET_HI;
      if (hold_left != 0)  res_if.ready <= 1'b0;
      else if (quiet)      res_if.ready <= 1'b1;
      else                 res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ------------------------------------------------------------------------
  // sequencing and end of run
  // ------------------------------------------------------------------------

  initial begin
    fill_directed();
    fill_random();
    // all commands out, every expected beat back
    do @(posedge clk);
    while (rst || cmd_queue.size() != 0 || cmd_if.valid || expected_results.size() != 0);
    // anything extra would surface here
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_results.size());
      err_count++;
    end
    $display("ran %0d commands (%0d ticks) in %0d cycles", cmds_issued, ticks_issued,
             cycle_count);
    $display("checked %0d result beats, %0d timer expiries, %0d mismatches", beats_seen,
             expiries, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/tmb_pkg.sv
sv/tmb_if.sv
sv/tmb_front.sv
sv/tmb_queue.sv
sv/tmb_back.sv
sv/oneshot_periodic_timer_bank.sv
test/tb_top.sv
